// ----- src/b64d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int RES_CNT_W   = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_CNT_W  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_CAPACITY = '0;

   localparam logic [15:0] CAP_RESET = 16'd4096;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_count;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]         n;
      result_type [MAX_RESULTS-1:0] entries;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (ch >= 8'h41 && ch <= 8'h5a) begin
         s.value = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7a) begin
         s.value = 6'(ch - 8'h61) + SEXTET_LOWER_BASE;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         s.value = 6'(ch - 8'h30) + SEXTET_DIGIT_BASE;
      end else if (ch == 8'h2b) begin
         s.value = SEXTET_PLUS;
      end else if (ch == 8'h2f) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ----- src/b64d_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the decoder: text characters in, results out.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  data_byte;
   logic [15:0] byte_count;
   logic        last;

   modport source (output valid, output item_kind, output data_byte, output byte_count,
                   output last, input ready);
   modport sink   (input valid, input item_kind, input data_byte, input byte_count,
                   input last, output ready);
endinterface
`default_nettype wire

// ----- src/b64d_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_csr
// APB register file holding the output capacity.
// ----------------------------------------------------------------------------
module b64d_csr
   import b64d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [15:0]           capacity
);

   logic [15:0] cap_ff;
   logic [15:0] cap_in;
   logic        hit;

   assign hit        = csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_CAPACITY;
   assign csr_pready = 1'b1;
   assign capacity   = cap_ff;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         cap_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = CSR_DATA_W'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/b64d_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_decode
// Input register, sextet lookup, group assembly, and byte and summary emission.
// ----------------------------------------------------------------------------
module b64d_decode
   import b64d_pkg::*;
#(
   parameter int LEN_BITS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   b64d_req_if.sink         req_bus,
   input  wire logic [15:0] capacity,
   input  wire logic        space_ok,
   output push_type         push
);

   localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          ch_ff;
   logic                eot_ff;
   logic [17:0]         acc_ff, acc_in;
   logic [1:0]          pos_ff, pos_in;
   logic                halted_ff, halted_in;
   logic [LEN_BITS-1:0] cnt_ff, cnt_in;

   logic                fire;
   logic                take;
   sextet_type          sx;
   logic                group_done;
   logic [23:0]         word;
   logic [2:0]          emit;
   logic [LEN_BITS-1:0] cnt [0:3];
   logic [RES_CNT_W-1:0] nb, n;

   assign fire          = in_valid_ff && space_ok;
   assign req_bus.ready = !in_valid_ff || fire;
   assign take          = req_bus.valid && req_bus.ready;

   assign sx         = sextet_of(ch_ff);
   assign group_done = !halted_ff && sx.ok && (pos_ff == 2'd3);
   assign word       = {acc_ff, sx.value};

   always_comb begin
      cnt[0] = cnt_ff;
      for (int b = 0; b < 3; b++) begin
         emit[b]  = group_done && (CMP_W'(cnt[b]) < CMP_W'(capacity));
         cnt[b+1] = cnt[b] + LEN_BITS'(emit[b]);
      end
      nb = RES_CNT_W'(emit[0]) + RES_CNT_W'(emit[1]) + RES_CNT_W'(emit[2]);
      n  = nb + RES_CNT_W'(eot_ff);
   end

   always_comb begin
      push.n = fire ? n : '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         push.entries[i].item_kind  = KIND_SUMMARY;
         push.entries[i].data_byte  = '0;
         push.entries[i].byte_count = 16'(cnt[3]);
         push.entries[i].last       = (RES_CNT_W'(i + 1) == n);
      end
      for (int i = 0; i < 3; i++) begin
         if (RES_CNT_W'(i) < nb) begin
            push.entries[i].item_kind  = KIND_DATA;
            push.entries[i].data_byte  = word[8*(2-i) +: 8];
            push.entries[i].byte_count = 16'(cnt[i+1]);
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      cnt_in    = cnt_ff;
      if (fire) begin
         if (!halted_ff) begin
            if (!sx.ok) begin
               halted_in = 1'b1;
            end else if (pos_ff != 2'd3) begin
               acc_in = {acc_ff[11:0], sx.value};
               pos_in = pos_ff + 2'd1;
            end else begin
               acc_in = '0;
               pos_in = '0;
               cnt_in = cnt[3];
            end
         end
         if (eot_ff) begin
            acc_in    = '0;
            pos_in    = '0;
            halted_in = 1'b0;
            cnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
         pos_ff      <= '0;
         halted_ff   <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
         halted_ff   <= halted_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ch_ff  <= req_bus.char_code;
         eot_ff <= req_bus.end_of_text;
      end
   end

endmodule
`default_nettype wire

// ----- src/b64d_result_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_result_fifo
// Result queue taking up to four results a cycle and giving one a cycle while rsp_bus is ready.
// ----------------------------------------------------------------------------
module b64d_result_fifo
   import b64d_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  push_type   push,
   output logic       space_ok,
   b64d_rsp_if.source rsp_bus
);

   result_type            mem_ff [0:FIFO_DEPTH-1];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;
   result_type            head;

   assign space_ok = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);
   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign head     = mem_ff[rd_ptr_ff];

   assign rsp_bus.valid      = count_ff != '0;
   assign rsp_bus.item_kind  = head.item_kind;
   assign rsp_bus.data_byte  = head.data_byte;
   assign rsp_bus.byte_count = head.byte_count;
   assign rsp_bus.last       = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_W'(i) < push.n) begin
            mem_ff[FIFO_PTR_W'(wr_ptr_ff + FIFO_PTR_W'(i))] <= push.entries[i];
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/base64_stream_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 text decoder: one character per transaction in, decoded bytes and an
// end-of-text summary out.
// ----------------------------------------------------------------------------
//  channel   direction  protocol      payload
//  req_bus   in         valid/ready   char_code, end_of_text
//  rsp_bus   out        valid/ready   item_kind, data_byte, byte_count, last
//  csr_*     in         APB           out_capacity at byte address 0
//
//  One character is taken per cycle unless decode stalls; it is decoded from the
//  input register, its results going to an eight-entry result queue. The queue
//  sends one result per cycle while rsp_bus is ready; a new character is decoded
//  only while at least four entries are free, so a stalled rsp_bus backs up into
//  req_bus. Reset clears the decode state and the queue and sets out_capacity to 4096.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit
   import b64d_pkg::*;
#(
   parameter int LEN_BITS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   b64d_req_if.sink                   req_bus,
   b64d_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [15:0] capacity;
   logic        space_ok;
   push_type    push;

   b64d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   b64d_decode #(
      .LEN_BITS (LEN_BITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .capacity (capacity),
      .space_ok (space_ok),
      .push     (push)
   );

   b64d_result_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire
